// File: rtl/pes_pkg.sv
package pes_pkg;

  localparam int FREQ_W       = 16;
  localparam int SQ_W         = 2 * FREQ_W;
  localparam int SUM_W        = 37;
  localparam int ROOT_W       = (SUM_W + 1) / 2;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int SCORE_W      = 21;
  localparam int MAX_ELEMENTS = 20;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [SCORE_W-1:0] OFFSET_RESET = SCORE_W'(65536);

  // register index carried in paddr[2]
  localparam logic REG_SCORE_OFFSET = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/pes_front.sv
module pes_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pes_pkg::FREQ_W-1:0]    freq_a,
  input  logic [pes_pkg::FREQ_W-1:0]    freq_b,
  input  logic                          last_element,
  input  pes_pkg::q_status_t            q_status,
  output logic                          push,
  output logic [pes_pkg::SUM_W-1:0]     push_data
);

  logic                          advance;
  logic                          s1_valid;
  logic                          s1_last;
  logic [pes_pkg::FREQ_W-1:0]    s1_diff;
  logic                          s2_valid;
  logic                          s2_last;
  logic [pes_pkg::SQ_W-1:0]      s2_sq;
  logic [pes_pkg::SUM_W-1:0]     square_sum;
  logic [pes_pkg::SUM_W-1:0]     square_sum_next;
  logic [pes_pkg::CNT_W-1:0]     element_count;
  logic [pes_pkg::CNT_W-1:0]     element_count_next;
  logic [pes_pkg::SUM_W:0]       sum_add;

  // a column end can only leave when the queue has room
  assign advance  = !(s2_valid && s2_last && q_status.full);
  assign in_stall = !advance;

  assign sum_add = {1'b0, square_sum} + (pes_pkg::SUM_W + 1)'(s2_sq);

  always_comb begin
    if (element_count >= pes_pkg::CNT_W'(pes_pkg::MAX_ELEMENTS)) begin
      square_sum_next    = pes_pkg::SUM_MAX;
      element_count_next = pes_pkg::CNT_W'(pes_pkg::MAX_ELEMENTS);
    end else begin
      square_sum_next    = sum_add[pes_pkg::SUM_W] ? pes_pkg::SUM_MAX
                                                   : sum_add[pes_pkg::SUM_W-1:0];
      element_count_next = element_count + pes_pkg::CNT_W'(1);
    end
  end

  assign push      = advance && s2_valid && s2_last;
  assign push_data = square_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      square_sum    <= '0;
      element_count <= '0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        if (s2_last) begin
          square_sum    <= '0;
          element_count <= '0;
        end else begin
          square_sum    <= square_sum_next;
          element_count <= element_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last <= last_element;
      s1_diff <= (freq_a >= freq_b) ? (freq_a - freq_b) : (freq_b - freq_a);
      s2_last <= s1_last;
      s2_sq   <= s1_diff * s1_diff;
    end
  end

endmodule

// File: rtl/pes_queue.sv
module pes_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [pes_pkg::SUM_W-1:0]     push_data,
  input  logic                          pop,
  output logic [pes_pkg::SUM_W-1:0]     pop_data,
  output pes_pkg::q_status_t            status
);

  logic [pes_pkg::SUM_W-1:0]   entries [pes_pkg::Q_DEPTH];
  logic [pes_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [pes_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [pes_pkg::Q_CNT_W-1:0] fill;

  assign status.full  = (fill == pes_pkg::Q_CNT_W'(pes_pkg::Q_DEPTH));
  assign status.empty = (fill == '0);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pes_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pes_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + pes_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - pes_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/pes_back.sv
module pes_back (
  input  logic                                clk,
  input  logic                                rst,
  input  pes_pkg::q_status_t                  q_status,
  output logic                                pop,
  input  logic [pes_pkg::SUM_W-1:0]           pop_data,
  input  logic signed [pes_pkg::SCORE_W-1:0]  score_offset,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pes_pkg::SCORE_W-1:0]  score
);

  localparam int DIFF_W = pes_pkg::SCORE_W + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                        state;
  logic [pes_pkg::SUM_W-1:0]     rem;
  logic [pes_pkg::SUM_W:0]       root;
  logic [pes_pkg::SUM_W-1:0]     bit_pos;
  logic [pes_pkg::SUM_W:0]       trial;
  logic                          take;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [pes_pkg::SCORE_W-1:0] score_next;
  logic                          out_free;

  assign pop      = (state == S_IDLE) && !q_status.empty;
  assign trial    = root + (pes_pkg::SUM_W + 1)'(bit_pos);
  assign take     = ({1'b0, rem} >= trial);
  assign out_free = !out_valid || !out_stall;

  assign diff = DIFF_W'(score_offset)
              - $signed({{(DIFF_W - pes_pkg::ROOT_W){1'b0}}, root[pes_pkg::ROOT_W-1:0]});

  always_comb begin
    if (diff[DIFF_W-1:pes_pkg::SCORE_W-1] == '0 ||
        diff[DIFF_W-1:pes_pkg::SCORE_W-1] == '1) begin
      score_next = diff[pes_pkg::SCORE_W-1:0];
    end else if (diff[DIFF_W-1]) begin
      score_next = {1'b1, {(pes_pkg::SCORE_W - 1){1'b0}}};
    end else begin
      score_next = {1'b0, {(pes_pkg::SCORE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          // one result bit per cycle, bit_pos walks down by powers of four
          if (bit_pos[0]) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rem     <= pop_data;
        root    <= '0;
        bit_pos <= pes_pkg::SUM_W'(1) << (2 * (pes_pkg::SQRT_STEPS - 1));
      end
      S_RUN: begin
        if (take) begin
          rem  <= rem - trial[pes_pkg::SUM_W-1:0];
          root <= (root >> 1) + (pes_pkg::SUM_W + 1)'(bit_pos);
        end else begin
          root <= root >> 1;
        end
        bit_pos <= bit_pos >> 2;
      end
      S_DONE: begin
        if (out_free) begin
          score <= score_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/profile_euclidean_score.sv
// Euclidean-distance score of two profile columns. Frequency pairs stream in
// one beat per clock while in_stall is low; each pair is differenced, squared
// and added into a saturating 37-bit sum over a three-stage front end.
// The beat flagged last_element closes the column: its sum goes into a
// two-entry queue and the accumulator restarts. Behind the queue an iterative
// square-root unit loads a column's sum from the queue while idle, forms one
// root bit per cycle, then writes the output register and raises out_valid;
// it pops the next column only after that. Columns of 21 or more beats
// stream without stalling while the output is not stalled; shorter ones see
// in_stall when the queue fills. score = score_offset - isqrt(sum), saturated
// to 21 bits, signed Q.16. More than MAX_ELEMENTS beats in one column force
// the sum to its maximum.
module profile_euclidean_score (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pes_pkg::FREQ_W-1:0]          freq_a,
  input  logic [pes_pkg::FREQ_W-1:0]          freq_b,
  input  logic                                last_element,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pes_pkg::SCORE_W-1:0]  score,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pes_pkg::PADDR_W-1:0]         paddr,
  input  logic [pes_pkg::PDATA_W-1:0]         pwdata,
  output logic [pes_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  logic signed [pes_pkg::SCORE_W-1:0] score_offset;
  pes_pkg::q_status_t                 q_status;
  logic                               push;
  logic [pes_pkg::SUM_W-1:0]          push_data;
  logic                               pop;
  logic [pes_pkg::SUM_W-1:0]          pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pes_pkg::REG_SCORE_OFFSET)
                ? pes_pkg::PDATA_W'(score_offset) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_offset <= pes_pkg::OFFSET_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pes_pkg::REG_SCORE_OFFSET) begin
      score_offset <= pwdata[pes_pkg::SCORE_W-1:0];
    end
  end

  pes_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .freq_a       (freq_a),
    .freq_b       (freq_b),
    .last_element (last_element),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  pes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  pes_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop          (pop),
    .pop_data     (pop_data),
    .score_offset (score_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .score        (score)
  );

endmodule
